// ===== rtl/core/bmps_pkg.sv =====
// Shared constants, widths and register codes of the bump-map pixel shader.
`timescale 1ns / 1ps
package bmps_pkg;

    localparam int PIX_W      = 10;
    localparam int PXQ_W      = PIX_W + 4;
    localparam int HGT_W      = 8;
    localparam int CH_W       = 8;
    localparam int POS_W      = 32;
    localparam int LCOL_W     = 24;
    localparam int LHGT_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LIGHT_CNT  = 3;

    // normal path
    localparam int GRAD_W    = 9;
    localparam int SQ_W      = 17;
    localparam int S_W       = 38;
    localparam int Q_ROOT_W  = 19;
    localparam int NRM_NUM_W = 34;
    localparam int NRM_QW    = 17;
    localparam int NRM_W     = 18;
    localparam int NZ_MAX    = 32767;

    // light path
    localparam int D2_W        = 34;
    localparam int DIST_W      = 17;
    localparam int DIST_MIN    = 2;
    localparam int ATT_BIAS    = 1600;
    localparam int ATT_NUM     = 52428800;
    localparam int ATT_NUM_W   = 26;
    localparam int ATT_QW      = 16;
    localparam int DOT_NUM_W   = 33;
    localparam int INT_QW      = 17;
    localparam int INTEN_W     = 16;
    localparam int INTEN_MAX   = 32768;
    localparam int CONTRIB_W   = 15;

    // color combine
    localparam int PROD_W      = 23;
    localparam int TOTAL_W     = 25;
    localparam int AMBIENT_Q15 = 417792;
    localparam int TQ_W        = 18;
    localparam int SAT_LIMIT   = 65280;

    // stage bookkeeping, counted from the input register
    localparam int NRM_LAT   = 3 + Q_ROOT_W + NRM_QW;
    localparam int LIGHT_LAT = NRM_LAT + INT_QW + 4;
    localparam int LXY_DLY   = NRM_LAT - 1;
    localparam int DIST_DLY  = NRM_LAT + 2 - (4 + DIST_W);
    localparam int ATT_DLY   = NRM_LAT + 3 + INT_QW - (4 + DIST_W + ATT_QW);
    localparam int BASE_DLY  = LIGHT_LAT + 2;
    localparam int VLD_N     = LIGHT_LAT + 4;

    localparam logic [LCOL_W-1:0] LIGHT0_COL_RST = 24'hFF3232;
    localparam logic [LCOL_W-1:0] LIGHT1_COL_RST = 24'h3232FF;
    localparam logic [LCOL_W-1:0] LIGHT2_COL_RST = 24'hFFFF32;
    localparam logic [LHGT_W-1:0] LIGHT_HGT_RST  = 16'd800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT0_POS,
        CFG_LIGHT1_POS,
        CFG_LIGHT2_POS,
        CFG_LIGHT0_COL,
        CFG_LIGHT1_COL,
        CFG_LIGHT2_COL,
        CFG_LIGHT_HGT
    } t_cfg_idx;

endpackage

// ===== rtl/core/bmps_delay.sv =====
// Enabled shift line that carries side data alongside the long units.
`timescale 1ns / 1ps
module bmps_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_tap [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[D-1];

endmodule

// ===== rtl/core/bmps_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module bmps_sqrt #(
    parameter int IN_W   = 38,
    parameter int ROOT_W = 19
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [IN_W-1:0]   i_val,
    output logic [ROOT_W-1:0] o_root
);

    localparam int W = IN_W + 1;

    logic [IN_W-1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam int B = ROOT_W - 1 - k;
        logic [IN_W-1:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [IN_W-1:0]   n_rem;
        logic [ROOT_W-1:0] n_root;
        logic [W-1:0]      inc;

        if (k == 0) begin : g_first
            assign rem_in  = i_val;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
        always_comb begin
            inc    = (W'(root_in) << (B + 1)) + (W'(1) << (2 * B));
            n_rem  = rem_in;
            n_root = root_in;
            if ({1'b0, rem_in} >= inc) begin
                n_rem     = IN_W'({1'b0, rem_in} - inc);
                n_root[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

// ===== rtl/core/bmps_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bmps_div #(
    parameter int N_W = 34,
    parameter int D_W = 19,
    parameter int Q_W = 17
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [Q_W-1:0] o_quo
);

    logic [N_W-1:0] r_rem [Q_W];
    logic [D_W-1:0] r_den [Q_W];
    logic [Q_W-1:0] r_quo [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int B = Q_W - 1 - k;
        logic [N_W-1:0] rem_in;
        logic [D_W-1:0] den_in;
        logic [Q_W-1:0] quo_in;
        logic [N_W-1:0] n_rem;
        logic [Q_W-1:0] n_quo;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        always_comb begin
            n_rem = rem_in;
            n_quo = quo_in;
            if ((rem_in >> B) >= N_W'(den_in)) begin
                n_rem    = rem_in - (N_W'(den_in) << B);
                n_quo[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= den_in;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

// ===== rtl/core/bmps_normal.sv =====
// Surface normal from height gradients, normalized to Q1.15.
`timescale 1ns / 1ps
module bmps_normal (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [bmps_pkg::GRAD_W-1:0]     i_gx,
    input  logic signed [bmps_pkg::GRAD_W-1:0]     i_gy,
    output logic signed [bmps_pkg::NRM_W-1:0]      o_nx,
    output logic signed [bmps_pkg::NRM_W-1:0]      o_ny,
    output logic signed [bmps_pkg::NRM_W-1:0]      o_nz
);

    localparam int SQ_W  = bmps_pkg::SQ_W;
    localparam int S_W   = bmps_pkg::S_W;
    localparam int QR_W  = bmps_pkg::Q_ROOT_W;
    localparam int NN_W  = bmps_pkg::NRM_NUM_W;
    localparam int NQ_W  = bmps_pkg::NRM_QW;
    localparam int NRM_W = bmps_pkg::NRM_W;
    localparam logic [NN_W-1:0] NZ_NUM = NN_W'(255) << 23;

    logic signed [17:0] gx_ext, gy_ext, gx2, gy2;
    logic [21:0]        s22;
    logic [7:0]         ax_d, ay_d;
    logic [1:0]         sgn_d;
    logic [10:0]        ax5, ay5;
    logic [QR_W-1:0]    q;
    logic [NQ_W-1:0]    qx, qy, qz;

    logic [SQ_W-1:0]  r_sq;
    logic [7:0]       r_ax, r_ay;
    logic             r_sx, r_sy;
    logic [S_W-1:0]   r_s;
    logic signed [NRM_W-1:0] r_nx, r_ny, r_nz;

    always_comb begin
        gx_ext = 18'(i_gx);
        gy_ext = 18'(i_gy);
        gx2    = gx_ext * gx_ext;
        gy2    = gy_ext * gy_ext;
        s22    = 22'(r_sq) * 22'd25 + 22'd65025;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= SQ_W'(gx2) + SQ_W'(gy2);
            r_ax <= i_gx[8] ? 8'(-i_gx) : 8'(i_gx);
            r_ay <= i_gy[8] ? 8'(-i_gy) : 8'(i_gy);
            r_sx <= i_gx[8];
            r_sy <= i_gy[8];
            r_s  <= {s22, 16'd0};
        end
    end

    bmps_sqrt #(.IN_W(S_W), .ROOT_W(QR_W)) u_sqrt (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_val (r_s),
        .o_root(q)
    );

    bmps_delay #(.W(16), .D(1 + QR_W)) u_mag_dly (
        .i_clk(i_clk),
        .i_en (i_en),
        .i_d  ({r_ax, r_ay}),
        .o_q  ({ax_d, ay_d})
    );

    bmps_delay #(.W(2), .D(1 + QR_W + NQ_W)) u_sgn_dly (
        .i_clk(i_clk),
        .i_en (i_en),
        .i_d  ({r_sx, r_sy}),
        .o_q  (sgn_d)
    );

    assign ax5 = 11'(ax_d) * 11'd5;
    assign ay5 = 11'(ay_d) * 11'd5;

    bmps_div #(.N_W(NN_W), .D_W(QR_W), .Q_W(NQ_W)) u_div_x (
        .i_clk(i_clk), .i_en(i_en), .i_num({ax5, 23'd0}), .i_den(q), .o_quo(qx)
    );

    bmps_div #(.N_W(NN_W), .D_W(QR_W), .Q_W(NQ_W)) u_div_y (
        .i_clk(i_clk), .i_en(i_en), .i_num({ay5, 23'd0}), .i_den(q), .o_quo(qy)
    );

    bmps_div #(.N_W(NN_W), .D_W(QR_W), .Q_W(NQ_W)) u_div_z (
        .i_clk(i_clk), .i_en(i_en), .i_num(NZ_NUM), .i_den(q), .o_quo(qz)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx <= sgn_d[1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            r_ny <= sgn_d[0] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            r_nz <= (qz > NQ_W'(bmps_pkg::NZ_MAX)) ? NRM_W'(bmps_pkg::NZ_MAX)
                                                    : $signed({1'b0, qz});
        end
    end

    assign o_nx = r_nx;
    assign o_ny = r_ny;
    assign o_nz = r_nz;

endmodule

// ===== rtl/core/bmps_light.sv =====
// One point light: distance, attenuation, clamped diffuse term.
`timescale 1ns / 1ps
module bmps_light (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [bmps_pkg::PXQ_W-1:0]            i_px,
    input  logic [bmps_pkg::PXQ_W-1:0]            i_py,
    input  logic [bmps_pkg::POS_W-1:0]            i_pos,
    input  logic [bmps_pkg::LHGT_W-1:0]           i_height,
    input  logic signed [bmps_pkg::NRM_W-1:0]     i_nx,
    input  logic signed [bmps_pkg::NRM_W-1:0]     i_ny,
    input  logic signed [bmps_pkg::NRM_W-1:0]     i_nz,
    output logic [bmps_pkg::CONTRIB_W-1:0]        o_contrib
);

    localparam int D2_W  = bmps_pkg::D2_W;
    localparam int DW    = bmps_pkg::DIST_W;
    localparam int AN_W  = bmps_pkg::ATT_NUM_W;
    localparam int AQ_W  = bmps_pkg::ATT_QW;
    localparam int DN_W  = bmps_pkg::DOT_NUM_W;
    localparam int IQ_W  = bmps_pkg::INT_QW;
    localparam int IN_W  = bmps_pkg::INTEN_W;
    localparam int CB_W  = bmps_pkg::CONTRIB_W;

    logic signed [35:0] lx_ext, ly_ext, lz_ext, lx2, ly2, lxd_ext, lyd_ext;
    logic signed [35:0] nx_ext, ny_ext, nz_ext;
    logic [31:0]        hz;
    logic [DW-1:0]      dist_raw, dist_c, dist_d;
    logic [AQ_W-1:0]    att, att_d;
    logic [35:0]        lxy_d;
    logic signed [37:0] dot;
    logic [IQ_W-1:0]    iq;
    logic [31:0]        ia;

    logic signed [17:0] r_lx, r_ly;
    logic [31:0]        r_lx2, r_ly2, r_lz2;
    logic [D2_W-1:0]    r_d2;
    logic [DW-1:0]      r_dist, r_dpl;
    logic signed [35:0] r_mx, r_my, r_mz;
    logic [DN_W-1:0]    r_num;
    logic [IN_W-1:0]    r_inten;
    logic [CB_W-1:0]    r_contrib;

    always_comb begin
        lx_ext  = 36'(r_lx);
        ly_ext  = 36'(r_ly);
        lx2     = lx_ext * lx_ext;
        ly2     = ly_ext * ly_ext;
        hz      = 32'(i_height);
        dist_c  = (dist_raw < DW'(bmps_pkg::DIST_MIN)) ? DW'(bmps_pkg::DIST_MIN) : dist_raw;
        lxd_ext = 36'($signed(lxy_d[35:18]));
        lyd_ext = 36'($signed(lxy_d[17:0]));
        lz_ext  = $signed({20'd0, i_height});
        nx_ext  = 36'(i_nx);
        ny_ext  = 36'(i_ny);
        nz_ext  = 36'(i_nz);
        dot     = 38'(r_mx) + 38'(r_my) + 38'(r_mz);
        ia      = 32'(r_inten) * 32'(att_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lx      <= $signed({2'b0, i_pos[15:0]}) - $signed({4'b0, i_px});
            r_ly      <= $signed({2'b0, i_pos[31:16]}) - $signed({4'b0, i_py});
            r_lx2     <= lx2[31:0];
            r_ly2     <= ly2[31:0];
            r_lz2     <= hz * hz;
            r_d2      <= D2_W'(r_lx2) + D2_W'(r_ly2) + D2_W'(r_lz2);
            r_dist    <= dist_c;
            r_dpl     <= dist_c + DW'(bmps_pkg::ATT_BIAS);
            r_mx      <= nx_ext * lxd_ext;
            r_my      <= ny_ext * lyd_ext;
            r_mz      <= nz_ext * lz_ext;
            // light behind the surface gives nothing
            r_num     <= (dot > 0) ? DN_W'(dot) : '0;
            r_inten   <= (iq > IQ_W'(bmps_pkg::INTEN_MAX)) ? IN_W'(bmps_pkg::INTEN_MAX)
                                                            : IN_W'(iq);
            r_contrib <= ia[29:15];
        end
    end

    bmps_sqrt #(.IN_W(D2_W), .ROOT_W(DW)) u_sqrt (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_val (r_d2),
        .o_root(dist_raw)
    );

    bmps_div #(.N_W(AN_W), .D_W(DW), .Q_W(AQ_W)) u_att_div (
        .i_clk(i_clk),
        .i_en (i_en),
        .i_num(AN_W'(bmps_pkg::ATT_NUM)),
        .i_den(r_dpl),
        .o_quo(att)
    );

    bmps_delay #(.W(36), .D(bmps_pkg::LXY_DLY)) u_lxy_dly (
        .i_clk(i_clk),
        .i_en (i_en),
        .i_d  ({r_lx, r_ly}),
        .o_q  (lxy_d)
    );

    bmps_delay #(.W(DW), .D(bmps_pkg::DIST_DLY)) u_dist_dly (
        .i_clk(i_clk),
        .i_en (i_en),
        .i_d  (r_dist),
        .o_q  (dist_d)
    );

    bmps_delay #(.W(AQ_W), .D(bmps_pkg::ATT_DLY)) u_att_dly (
        .i_clk(i_clk),
        .i_en (i_en),
        .i_d  (att),
        .o_q  (att_d)
    );

    bmps_div #(.N_W(DN_W), .D_W(DW), .Q_W(IQ_W)) u_int_div (
        .i_clk(i_clk),
        .i_en (i_en),
        .i_num(r_num),
        .i_den(dist_d),
        .o_quo(iq)
    );

    assign o_contrib = r_contrib;

endmodule

// ===== rtl/core/bump_map_pixel_shader.sv =====
// Top level of the bump-mapped pixel shader with three point lights.
//
//  channel  direction  handshake                  word
//  in       to block   i_in_valid / o_in_stall    pixel coords, 4 heights, base color
//  out      from block o_out_valid / i_out_stall  lit red, green, blue
//  cfg      to block   i_cfg_wr_en                register index + data
//
// One pixel per clock sustained while a stalled output does not hold the pipe.
// Latency is set by the chain of one-bit-per-stage square root and divider units.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stalled output freezes the pipe only when its last stage holds a word;
// bubbles drain, so input keeps flowing while a result waits.
`timescale 1ns / 1ps
module bump_map_pixel_shader #(
    parameter int COORD_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [bmps_pkg::PIX_W-1:0]         i_pixel_x,
    input  logic [bmps_pkg::PIX_W-1:0]         i_pixel_y,
    input  logic [bmps_pkg::HGT_W-1:0]         i_height_left,
    input  logic [bmps_pkg::HGT_W-1:0]         i_height_right,
    input  logic [bmps_pkg::HGT_W-1:0]         i_height_up,
    input  logic [bmps_pkg::HGT_W-1:0]         i_height_down,
    input  logic [bmps_pkg::CH_W-1:0]          i_base_red,
    input  logic [bmps_pkg::CH_W-1:0]          i_base_green,
    input  logic [bmps_pkg::CH_W-1:0]          i_base_blue,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [bmps_pkg::CH_W-1:0]          o_out_red,
    output logic [bmps_pkg::CH_W-1:0]          o_out_green,
    output logic [bmps_pkg::CH_W-1:0]          o_out_blue,
    input  logic                               i_cfg_wr_en,
    input  logic [bmps_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [bmps_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int PW    = bmps_pkg::PIX_W;
    localparam int PXQ_W = bmps_pkg::PXQ_W;
    localparam int NL    = bmps_pkg::LIGHT_CNT;
    localparam int CB_W  = bmps_pkg::CONTRIB_W;
    localparam int PR_W  = bmps_pkg::PROD_W;
    localparam int TT_W  = bmps_pkg::TOTAL_W;
    localparam int TQ_W  = bmps_pkg::TQ_W;
    localparam int VN    = bmps_pkg::VLD_N;
    localparam logic [PW-1:0] CMASK = PW'((64'd1 << COORD_BITS) - 64'd1);

    logic adv;
    logic v_last;
    logic signed [bmps_pkg::NRM_W-1:0] nx, ny, nz;
    logic [CB_W-1:0] contrib [NL];
    logic [23:0]     base_d;
    logic [32:0]     bt [3];
    logic [16:0]     dv [3];

    logic [bmps_pkg::POS_W-1:0]  r_pos [NL];
    logic [bmps_pkg::LCOL_W-1:0] r_col [NL];
    logic [bmps_pkg::LHGT_W-1:0] r_height;

    logic signed [bmps_pkg::GRAD_W-1:0] r_gx, r_gy;
    logic [PXQ_W-1:0] r_px, r_py;
    logic [23:0]      r_base;
    logic [VN-1:0]    r_vld;
    logic [PR_W-1:0]  r_prod [NL][3];
    logic [TT_W-1:0]  r_total [3];
    logic [TQ_W-1:0]  r_tq [3];
    logic             r_out_valid;
    logic [7:0]       r_out [3];

    // pipe holds only when the last stage has a word and the output is blocked
    assign v_last     = r_vld[VN-1];
    assign adv        = ~(v_last & r_out_valid & i_out_stall);
    assign o_in_stall = ~(adv & i_rst_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_pos[2] <= '0;
            r_col[0] <= bmps_pkg::LIGHT0_COL_RST;
            r_col[1] <= bmps_pkg::LIGHT1_COL_RST;
            r_col[2] <= bmps_pkg::LIGHT2_COL_RST;
            r_height <= bmps_pkg::LIGHT_HGT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                bmps_pkg::CFG_LIGHT0_POS: r_pos[0] <= i_cfg_wdata;
                bmps_pkg::CFG_LIGHT1_POS: r_pos[1] <= i_cfg_wdata;
                bmps_pkg::CFG_LIGHT2_POS: r_pos[2] <= i_cfg_wdata;
                bmps_pkg::CFG_LIGHT0_COL: r_col[0] <= i_cfg_wdata[23:0];
                bmps_pkg::CFG_LIGHT1_COL: r_col[1] <= i_cfg_wdata[23:0];
                bmps_pkg::CFG_LIGHT2_COL: r_col[2] <= i_cfg_wdata[23:0];
                bmps_pkg::CFG_LIGHT_HGT:  r_height <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[VN-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_gx   <= $signed({1'b0, i_height_right}) - $signed({1'b0, i_height_left});
            r_gy   <= $signed({1'b0, i_height_down}) - $signed({1'b0, i_height_up});
            r_px   <= {i_pixel_x & CMASK, 4'd0};
            r_py   <= {i_pixel_y & CMASK, 4'd0};
            r_base <= {i_base_red, i_base_green, i_base_blue};
        end
    end

    bmps_normal u_normal (
        .i_clk(i_clk),
        .i_en (adv),
        .i_gx (r_gx),
        .i_gy (r_gy),
        .o_nx (nx),
        .o_ny (ny),
        .o_nz (nz)
    );

    for (genvar l = 0; l < NL; l++) begin : g_light
        bmps_light u_light (
            .i_clk    (i_clk),
            .i_en     (adv),
            .i_px     (r_px),
            .i_py     (r_py),
            .i_pos    (r_pos[l]),
            .i_height (r_height),
            .i_nx     (nx),
            .i_ny     (ny),
            .i_nz     (nz),
            .o_contrib(contrib[l])
        );
    end

    bmps_delay #(.W(24), .D(bmps_pkg::BASE_DLY)) u_base_dly (
        .i_clk(i_clk),
        .i_en (adv),
        .i_d  (r_base),
        .o_q  (base_d)
    );

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            bt[c] = 33'(base_d[23-8*c -: 8]) * 33'(r_total[c]);
            // floor(t/255) for t below 65280
            dv[c] = (17'(r_tq[c][15:0]) + 17'(r_tq[c][15:8]) + 17'd1) >> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < NL; l++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[l][c] <= PR_W'(contrib[l]) * PR_W'(r_col[l][23-8*c -: 8]);
                end
            end
            for (int c = 0; c < 3; c++) begin
                r_total[c] <= TT_W'(r_prod[0][c]) + TT_W'(r_prod[1][c])
                            + TT_W'(r_prod[2][c]) + TT_W'(bmps_pkg::AMBIENT_Q15);
                r_tq[c]    <= bt[c][32:15];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= v_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= (r_tq[c] >= TQ_W'(bmps_pkg::SAT_LIMIT)) ? 8'd255 : dv[c][7:0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];

endmodule
